FILE: src/assert_macros.svh
// Assertion macros shared by the compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define YAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define YAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/yac_pkg.sv
// Shared types, constants and control structs of the YUV420 canvas compositor.
`default_nettype none

package yac_pkg;

	// Canvas store dimensions.
	localparam int MAX_CANVAS_WIDTH  = 512;
	localparam int MAX_CANVAS_HEIGHT = 512;
	localparam int CHROMA_WIDTH      = MAX_CANVAS_WIDTH / 2;
	localparam int CHROMA_HEIGHT     = MAX_CANVAS_HEIGHT / 2;

	localparam int LX_W = $clog2(MAX_CANVAS_WIDTH);
	localparam int LY_W = $clog2(MAX_CANVAS_HEIGHT);
	localparam int CX_W = $clog2(CHROMA_WIDTH);
	localparam int CY_W = $clog2(CHROMA_HEIGHT);

	localparam int LUMA_DEPTH   = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
	localparam int CHROMA_DEPTH = CHROMA_WIDTH * CHROMA_HEIGHT;
	localparam int LUMA_AW      = $clog2(LUMA_DEPTH);
	localparam int CHROMA_AW    = $clog2(CHROMA_DEPTH);

	// Widths able to hold a canvas extent itself (0 .. maximum).
	localparam int CW_LIM_W = $clog2(MAX_CANVAS_WIDTH + 1);
	localparam int CH_LIM_W = $clog2(MAX_CANVAS_HEIGHT + 1);
	localparam int AX_W     = (CW_LIM_W > CH_LIM_W) ? CW_LIM_W : CH_LIM_W;

	// Item and register field widths.
	localparam int CMD_W      = 2;
	localparam int PLANE_W    = 2;
	localparam int COORD_W    = 12;
	localparam int SAMPLE_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int CLIP_W     = 16;
	localparam int SUM_W      = 14;

	localparam logic [SAMPLE_W-1:0] LUMA_RESET   = 8'h00;
	localparam logic [SAMPLE_W-1:0] LUMA_FILL    = 8'h55;
	localparam logic [SAMPLE_W-1:0] CHROMA_FILL  = 8'h80;
	localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [SAMPLE_W-1:0] ALPHA_CLEAR  = 8'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_BLEND = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [PLANE_W-1:0] {
		PLANE_Y  = 2'd0,
		PLANE_CB = 2'd1,
		PLANE_CR = 2'd2
	} plane_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CANVAS_WIDTH  = 3'd0,
		REG_CANVAS_HEIGHT = 3'd1,
		REG_SRC_WIDTH     = 3'd2,
		REG_SRC_HEIGHT    = 3'd3,
		REG_POS_X         = 3'd4,
		REG_POS_Y         = 3'd5,
		REG_ALPHA         = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [9:0]         canvas_width;
		logic [9:0]         canvas_height;
		logic [11:0]        src_width;
		logic [11:0]        src_height;
		logic signed [12:0] pos_x;
		logic signed [12:0] pos_y;
		logic [7:0]         alpha;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic sweep_start;
		logic sweep;
		logic lookup;
		logic update;
		logic load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: src/yac_req_if.sv
// Request channel: one command item with plane, coordinates and sample.
`default_nettype none

interface yac_req_if;
	logic                          valid;
	logic                          ready;
	logic [yac_pkg::CMD_W-1:0]     cmd;
	logic [yac_pkg::PLANE_W-1:0]   plane;
	logic [yac_pkg::COORD_W-1:0]   col;
	logic [yac_pkg::COORD_W-1:0]   row;
	logic [yac_pkg::SAMPLE_W-1:0]  sample_value;

	modport source (output valid, cmd, plane, col, row, sample_value, input ready);
	modport sink (input valid, cmd, plane, col, row, sample_value, output ready);
endinterface

`default_nettype wire

FILE: src/yac_rsp_if.sv
// Response channel: one canvas sample item per read command.
`default_nettype none

interface yac_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [yac_pkg::SAMPLE_W-1:0]  read_value;

	modport source (output valid, read_value, input ready);
	modport sink (input valid, read_value, output ready);
endinterface

`default_nettype wire

FILE: src/yac_cfg.sv
// Configuration register file of the compositor.
`default_nettype none

module yac_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [yac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [yac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output yac_pkg::cfg_t                    cfg
);
	import yac_pkg::*;

	cfg_t regs_q;

	assign cfg = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.canvas_width  <= 10'd512;
			regs_q.canvas_height <= 10'd512;
			regs_q.src_width     <= '0;
			regs_q.src_height    <= '0;
			regs_q.pos_x         <= '0;
			regs_q.pos_y         <= '0;
			regs_q.alpha         <= ALPHA_OPAQUE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CANVAS_WIDTH:  regs_q.canvas_width  <= cfg_wdata[9:0];
				REG_CANVAS_HEIGHT: regs_q.canvas_height <= cfg_wdata[9:0];
				REG_SRC_WIDTH:     regs_q.src_width     <= cfg_wdata[11:0];
				REG_SRC_HEIGHT:    regs_q.src_height    <= cfg_wdata[11:0];
				REG_POS_X:         regs_q.pos_x         <= $signed(cfg_wdata[12:0]);
				REG_POS_Y:         regs_q.pos_y         <= $signed(cfg_wdata[12:0]);
				REG_ALPHA:         regs_q.alpha         <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/yac_ctrl.sv
// Controller state machine: sequences lookup, fetch, update or result, and sweeps.
`default_nettype none

module yac_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [yac_pkg::CMD_W-1:0]   req_cmd,
	output logic                        req_ready,
	input  yac_pkg::dp_status_t         status,
	output yac_pkg::dp_cmd_t            ctl
);
	import yac_pkg::*;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_LOOKUP,
		ST_FETCH,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	state_t           state_q;
	logic [CMD_W-1:0] item_cmd_q;
	logic             accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		ctl             = '0;
		ctl.load_item   = accept;
		ctl.sweep_start = accept && (req_cmd == CMD_CLEAR);
		ctl.sweep       = (state_q == ST_SWEEP);
		ctl.lookup      = (state_q == ST_LOOKUP);
		ctl.update      = (state_q == ST_UPDATE);
		ctl.load_out    = (state_q == ST_RESULT) && !status.out_busy;
	end

	// Out of reset the machine sweeps the whole store to its reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			item_cmd_q <= CMD_BLEND;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (status.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						item_cmd_q <= req_cmd;
						case (req_cmd)
							CMD_BLEND, CMD_READ: state_q <= ST_LOOKUP;
							CMD_CLEAR:           state_q <= ST_SWEEP;
							default:             state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOOKUP: state_q <= ST_FETCH;
				ST_FETCH: begin
					state_q <= (item_cmd_q == CMD_READ) ? ST_RESULT : ST_UPDATE;
				end
				ST_UPDATE: state_q <= ST_IDLE;
				ST_RESULT: begin
					if (!status.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/yac_dp.sv
// Datapath: clipping, address generation, canvas stores, blend unit and output register.
`default_nettype none

module yac_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  yac_pkg::cfg_t                 cfg,
	input  yac_pkg::dp_cmd_t              ctl,
	output yac_pkg::dp_status_t           status,
	input  logic [yac_pkg::CMD_W-1:0]     req_cmd,
	input  logic [yac_pkg::PLANE_W-1:0]   req_plane,
	input  logic [yac_pkg::COORD_W-1:0]   req_col,
	input  logic [yac_pkg::COORD_W-1:0]   req_row,
	input  logic [yac_pkg::SAMPLE_W-1:0]  req_sample,
	yac_rsp_if.source                     rsp
);
	import yac_pkg::*;

	// Clip of one axis: canvas start, source start and overlap length.
	typedef struct packed {
		logic               ok;
		logic [AX_W-1:0]    d;
		logic [COORD_W-1:0] s;
		logic [AX_W-1:0]    len;
	} axis_t;

	function automatic axis_t clip_axis(input logic signed [12:0] pos,
		input logic [COORD_W-1:0] sz, input logic [AX_W-1:0] cz);
		logic signed [CLIP_W-1:0] p;
		logic signed [CLIP_W-1:0] z;
		logic signed [CLIP_W-1:0] c;
		logic signed [CLIP_W-1:0] a;
		logic signed [CLIP_W-1:0] b;
		logic signed [CLIP_W-1:0] len;
		axis_t r;
		p = CLIP_W'(pos);
		z = CLIP_W'(sz);
		c = CLIP_W'(cz);
		r = '0;
		if (p >= 0) begin
			a    = z;
			b    = c - p;
			len  = (a < b) ? a : b;
			r.ok = (p < c) && (len > 0);
			r.d  = AX_W'(p);
		end else begin
			a    = z + p;
			b    = c;
			len  = (a < b) ? a : b;
			r.ok = (len > 0);
			r.s  = COORD_W'(-p);
		end
		r.len = AX_W'(len);
		return r;
	endfunction

	// Canvas stores.
	logic [SAMPLE_W-1:0] luma_mem [LUMA_DEPTH];
	logic [SAMPLE_W-1:0] cb_mem   [CHROMA_DEPTH];
	logic [SAMPLE_W-1:0] cr_mem   [CHROMA_DEPTH];

	// Effective canvas size and clip, refreshed every cycle from the registers.
	logic [CW_LIM_W-1:0] eff_cw;
	logic [CH_LIM_W-1:0] eff_ch;
	logic [CW_LIM_W-1:0] eff_cw_q;
	logic [CH_LIM_W-1:0] eff_ch_q;
	axis_t               clip_x_q;
	axis_t               clip_y_q;

	// Accepted item.
	logic [CMD_W-1:0]    cmd_q;
	logic [PLANE_W-1:0]  plane_q;
	logic [COORD_W-1:0]  col_q;
	logic [COORD_W-1:0]  row_q;
	logic [SAMPLE_W-1:0] sample_q;

	// Lookup results.
	logic                 hit_q;
	logic [LUMA_AW-1:0]   luma_addr_q;
	logic [CHROMA_AW-1:0] chroma_addr_q;

	// Read data.
	logic [SAMPLE_W-1:0] luma_rd_q;
	logic [SAMPLE_W-1:0] cb_rd_q;
	logic [SAMPLE_W-1:0] cr_rd_q;

	// Sweep counters.
	logic            init_q;
	logic [LX_W-1:0] sw_col_q;
	logic [LY_W-1:0] sw_row_q;

	// Output register.
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_data_q;

	assign eff_cw = (32'(cfg.canvas_width) > MAX_CANVAS_WIDTH) ?
		CW_LIM_W'(MAX_CANVAS_WIDTH) : CW_LIM_W'(cfg.canvas_width);
	assign eff_ch = (32'(cfg.canvas_height) > MAX_CANVAS_HEIGHT) ?
		CH_LIM_W'(MAX_CANVAS_HEIGHT) : CH_LIM_W'(cfg.canvas_height);

	always_ff @(posedge clk) begin
		eff_cw_q <= eff_cw;
		eff_ch_q <= eff_ch;
		clip_x_q <= clip_axis(cfg.pos_x, cfg.src_width, AX_W'(eff_cw));
		clip_y_q <= clip_axis(cfg.pos_y, cfg.src_height, AX_W'(eff_ch));
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q    <= req_cmd;
			plane_q  <= req_plane;
			col_q    <= req_col;
			row_q    <= req_row;
			sample_q <= req_sample;
		end
	end

	// ---------------- Lookup: clip test and address ----------------
	logic [SUM_W-1:0]   col_e;
	logic [SUM_W-1:0]   row_e;
	logic               clip_ok;
	logic [AX_W-1:0]    rows_even;
	logic [COORD_W-1:0] csx;
	logic [COORD_W-1:0] csy;
	logic [AX_W-1:0]    cwc;
	logic [AX_W-1:0]    chc;
	logic               bl_hit;
	logic               bc_hit;
	logic               rl_hit;
	logic               rc_hit;
	logic [LX_W-1:0]    bl_x;
	logic [LY_W-1:0]    bl_y;
	logic [CX_W-1:0]    bc_x;
	logic [CY_W-1:0]    bc_y;
	logic               is_read;
	logic               hit;
	logic [LX_W-1:0]    lx;
	logic [LY_W-1:0]    ly;
	logic [CX_W-1:0]    cx;
	logic [CY_W-1:0]    cy;

	always_comb begin
		col_e     = SUM_W'(col_q);
		row_e     = SUM_W'(row_q);
		clip_ok   = clip_x_q.ok && clip_y_q.ok;
		// Luma covers only an even number of rows of the clip.
		rows_even = {clip_y_q.len[AX_W-1:1], 1'b0};
		csx       = clip_x_q.s >> 1;
		csy       = clip_y_q.s >> 1;
		cwc       = clip_x_q.len >> 1;
		chc       = clip_y_q.len >> 1;

		bl_hit = clip_ok
			&& (col_e >= SUM_W'(clip_x_q.s))
			&& (col_e < SUM_W'(clip_x_q.s) + SUM_W'(clip_x_q.len))
			&& (row_e >= SUM_W'(clip_y_q.s))
			&& (row_e < SUM_W'(clip_y_q.s) + SUM_W'(rows_even));
		bl_x = LX_W'(col_e - SUM_W'(clip_x_q.s) + SUM_W'(clip_x_q.d));
		bl_y = LY_W'(row_e - SUM_W'(clip_y_q.s) + SUM_W'(clip_y_q.d));

		bc_hit = clip_ok
			&& (col_e >= SUM_W'(csx))
			&& (col_e < SUM_W'(csx) + SUM_W'(cwc))
			&& (row_e >= SUM_W'(csy))
			&& (row_e < SUM_W'(csy) + SUM_W'(chc));
		bc_x = CX_W'(col_e - SUM_W'(csx) + SUM_W'(clip_x_q.d >> 1));
		bc_y = CY_W'(row_e - SUM_W'(csy) + SUM_W'(clip_y_q.d >> 1));

		rl_hit = (col_e < SUM_W'(eff_cw_q)) && (row_e < SUM_W'(eff_ch_q));
		rc_hit = (col_e < SUM_W'(eff_cw_q >> 1)) && (row_e < SUM_W'(eff_ch_q >> 1));

		is_read = (cmd_q == CMD_READ);
		case (plane_q)
			PLANE_Y:            hit = is_read ? rl_hit : bl_hit;
			PLANE_CB, PLANE_CR: hit = is_read ? rc_hit : bc_hit;
			default:            hit = 1'b0;
		endcase
		lx = is_read ? LX_W'(col_q) : bl_x;
		ly = is_read ? LY_W'(row_q) : bl_y;
		cx = is_read ? CX_W'(col_q) : bc_x;
		cy = is_read ? CY_W'(row_q) : bc_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.lookup) begin
			hit_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.lookup) begin
			luma_addr_q   <= LUMA_AW'(ly) * LUMA_AW'(MAX_CANVAS_WIDTH) + LUMA_AW'(lx);
			chroma_addr_q <= CHROMA_AW'(cy) * CHROMA_AW'(CHROMA_WIDTH) + CHROMA_AW'(cx);
		end
	end

	// ---------------- Blend unit ----------------
	logic [SAMPLE_W-1:0]        old_val;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [17:0]         prod;
	logic signed [17:0]         mix;
	logic [SAMPLE_W-1:0]        blend_val;
	logic                       blend_we;

	always_comb begin
		case (plane_q)
			PLANE_Y:  old_val = luma_rd_q;
			PLANE_CB: old_val = cb_rd_q;
			PLANE_CR: old_val = cr_rd_q;
			default:  old_val = '0;
		endcase
		// d*(256-a) + s*a is rewritten as 256*d + a*(s-d): one multiplier.
		diff      = $signed({1'b0, sample_q}) - $signed({1'b0, old_val});
		prod      = $signed({1'b0, cfg.alpha}) * diff;
		mix       = $signed({2'b00, old_val, 8'h00}) + prod;
		blend_val = (cfg.alpha == ALPHA_OPAQUE) ? sample_q : mix[15:8];
		blend_we  = ctl.update && hit_q && (cfg.alpha != ALPHA_CLEAR);
	end

	// ---------------- Sweep of the stores ----------------
	logic [CW_LIM_W-1:0]  lim_w;
	logic [CH_LIM_W-1:0]  lim_h;
	logic                 sw_luma_in;
	logic                 sw_chroma_in;
	logic                 col_last;
	logic                 row_last;
	logic [LUMA_AW-1:0]   sw_luma_addr;
	logic [CHROMA_AW-1:0] sw_chroma_addr;

	always_comb begin
		lim_w = init_q ? CW_LIM_W'(MAX_CANVAS_WIDTH) : eff_cw_q;
		lim_h = init_q ? CH_LIM_W'(MAX_CANVAS_HEIGHT) : eff_ch_q;
		sw_luma_in   = (CW_LIM_W'(sw_col_q) < lim_w) && (CH_LIM_W'(sw_row_q) < lim_h);
		sw_chroma_in = (CW_LIM_W'(sw_col_q) < (lim_w >> 1))
			&& (CH_LIM_W'(sw_row_q) < (lim_h >> 1));
		col_last = (CW_LIM_W'(sw_col_q) + CW_LIM_W'(1)) >= lim_w;
		row_last = (CH_LIM_W'(sw_row_q) + CH_LIM_W'(1)) >= lim_h;
		sw_luma_addr   = LUMA_AW'(sw_row_q) * LUMA_AW'(MAX_CANVAS_WIDTH) + LUMA_AW'(sw_col_q);
		sw_chroma_addr = CHROMA_AW'(sw_row_q) * CHROMA_AW'(CHROMA_WIDTH)
			+ CHROMA_AW'(sw_col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q   <= 1'b1;
			sw_col_q <= '0;
			sw_row_q <= '0;
		end else if (ctl.sweep_start) begin
			init_q   <= 1'b0;
			sw_col_q <= '0;
			sw_row_q <= '0;
		end else if (ctl.sweep) begin
			if (col_last) begin
				sw_col_q <= '0;
				sw_row_q <= sw_row_q + LY_W'(1);
			end else begin
				sw_col_q <= sw_col_q + LX_W'(1);
			end
		end
	end

	// ---------------- Store ports ----------------
	logic                 luma_we;
	logic                 cb_we;
	logic                 cr_we;
	logic [LUMA_AW-1:0]   luma_waddr;
	logic [CHROMA_AW-1:0] chroma_waddr;
	logic [SAMPLE_W-1:0]  luma_wdata;
	logic [SAMPLE_W-1:0]  chroma_wdata;

	always_comb begin
		luma_we = (ctl.sweep && sw_luma_in) || (blend_we && (plane_q == PLANE_Y));
		cb_we   = (ctl.sweep && sw_chroma_in) || (blend_we && (plane_q == PLANE_CB));
		cr_we   = (ctl.sweep && sw_chroma_in) || (blend_we && (plane_q == PLANE_CR));
		luma_waddr   = ctl.sweep ? sw_luma_addr : luma_addr_q;
		chroma_waddr = ctl.sweep ? sw_chroma_addr : chroma_addr_q;
		luma_wdata   = ctl.sweep ? (init_q ? LUMA_RESET : LUMA_FILL) : blend_val;
		chroma_wdata = ctl.sweep ? CHROMA_FILL : blend_val;
	end

	always_ff @(posedge clk) begin
		if (luma_we) luma_mem[luma_waddr] <= luma_wdata;
		luma_rd_q <= luma_mem[luma_addr_q];
	end

	always_ff @(posedge clk) begin
		if (cb_we) cb_mem[chroma_waddr] <= chroma_wdata;
		cb_rd_q <= cb_mem[chroma_addr_q];
	end

	always_ff @(posedge clk) begin
		if (cr_we) cr_mem[chroma_waddr] <= chroma_wdata;
		cr_rd_q <= cr_mem[chroma_addr_q];
	end

	// ---------------- Output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) out_data_q <= hit_q ? old_val : '0;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_data_q;

	assign status.sweep_last = col_last && row_last;
	assign status.out_busy   = out_valid_q && !rsp.ready;

endmodule

`default_nettype wire

FILE: src/yuv420_canvas_alpha_compositor.sv
// YUV420 canvas compositor top level. The canvas is held in three stores with one
// write and one read port each (luma 512x512, Cb and Cr 256x256, one byte each). A
// blend item places its source sample through the clip of the source rectangle at
// (pos_x, pos_y) and copies, skips or alpha-blends it into the canvas; a read item
// returns one canvas sample, 0 outside the canvas; a clear item fills the canvas
// area with luma 0x55 and chroma 0x80. Blend and read items pass, from acceptance
// to the next acceptance, through the read-modify-write of the store (lookup,
// registered read, update or result). A read whose result is ready while the
// previous result still waits in the output register holds in its result state
// until that one is taken. A clear sweeps the effective canvas area (width and
// height each saturated to 512); the sweep writes one luma entry per cycle and
// the chroma entries alongside. After reset the block first sweeps the full stores
// to their reset contents and accepts no item during that sweep. Configuration
// writes are taken in any cycle, but the clip and canvas size are read live, so
// the user must change registers only while no item is in flight; the block
// itself does not enforce this. A finished read result waits in an output
// register, so the next item is accepted while the result is still pending.
`default_nettype none

`include "assert_macros.svh"

module yuv420_canvas_alpha_compositor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [yac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [yac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	yac_req_if.sink                          req,
	yac_rsp_if.source                        rsp
);
	import yac_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    ctl;
	dp_status_t status;
	logic       req_ready;

	assign req.ready = req_ready;

	yac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	yac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.status    (status),
		.ctl       (ctl)
	);

	yac_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctl        (ctl),
		.status     (status),
		.req_cmd    (req.cmd),
		.req_plane  (req.plane),
		.req_col    (req.col),
		.req_row    (req.row),
		.req_sample (req.sample_value),
		.rsp        (rsp)
	);

	// A store sweep never overlaps item intake or a blend write.
	`YAC_ASSERT_NOW(a_sweep_blocks_items, ctl.sweep, !req_ready && !ctl.update, "item taken during sweep")
	// A pending result is never overwritten.
	`YAC_ASSERT_NOW(a_out_no_overwrite, ctl.load_out, !(rsp.valid && !rsp.ready), "result overwritten")
	// Loading the output register presents a result in the next cycle.
	`YAC_ASSERT_NEXT(a_out_after_load, ctl.load_out, rsp.valid, "loaded result not presented")
	// A result item only appears when the output register was loaded.
	`YAC_ASSERT_NEXT(a_out_source, !rsp.valid && !ctl.load_out, !rsp.valid, "result without a read")

endmodule

`default_nettype wire
